/* sv/sdrf_pkg.sv */
package sdrf_pkg;

  // Number of switches handled side by side, one lane each.
  localparam int NumSwitches = 2;
  localparam int CountW      = 8;

  // Tick timing that sets the reset values of the count registers.
  localparam int PollRateHz = 200;
  localparam int PressMs    = 10;
  localparam int ReleaseMs  = 100;
  localparam int TickMs     = 1000 / PollRateHz;

  localparam logic [CountW-1:0] PressCountRst   = CountW'(PressMs / TickMs);
  localparam logic [CountW-1:0] ReleaseCountRst = CountW'(ReleaseMs / TickMs);

  // Configuration port geometry: two 8-bit registers on a 32-bit bus at byte addresses 0 and 4.
  localparam int ApbDataW = 32;
  localparam int PaddrW   = 3;

  typedef enum logic {
    RegPressCount   = 1'b0,
    RegReleaseCount = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpClear = 2'd1,
    OpReset = 2'd2
  } op_e;

  typedef struct packed {
    logic [CountW-1:0] press_count;
    logic [CountW-1:0] release_count;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic clear_state;
  } lane_ctrl_t;

  typedef struct packed {
    logic pressed;
    logic released;
  } lane_out_t;

endpackage

/* sv/sdrf_cfg.sv */
module sdrf_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sdrf_pkg::PaddrW-1:0]      paddr,
  input  logic [sdrf_pkg::ApbDataW-1:0]    pwdata,
  output logic [sdrf_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,
  output sdrf_pkg::cfg_t                   cfg_o
);

  logic [sdrf_pkg::CountW-1:0] press_q, press_d;
  logic [sdrf_pkg::CountW-1:0] release_q, release_d;
  logic                        wr_en;
  sdrf_pkg::reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = sdrf_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    press_d   = press_q;
    release_d = release_q;
    if (wr_en) begin
      unique case (idx)
        sdrf_pkg::RegPressCount:   press_d   = pwdata[sdrf_pkg::CountW-1:0];
        sdrf_pkg::RegReleaseCount: release_d = pwdata[sdrf_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sdrf_pkg::RegPressCount:
        prdata = sdrf_pkg::ApbDataW'(press_q);
      sdrf_pkg::RegReleaseCount:
        prdata = sdrf_pkg::ApbDataW'(release_q);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q   <= sdrf_pkg::PressCountRst;
      release_q <= sdrf_pkg::ReleaseCountRst;
    end else begin
      press_q   <= press_d;
      release_q <= release_d;
    end
  end

  assign cfg_o.press_count   = press_q;
  assign cfg_o.release_count = release_q;

endmodule

/* sv/sdrf_lane.sv */
module sdrf_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdrf_pkg::lane_ctrl_t ctrl_i,
  input  logic                 raw_released_i,
  input  sdrf_pkg::cfg_t       cfg_i,
  output sdrf_pkg::lane_out_t  next_o
);

  logic                        pressed_q, pressed_d;
  logic [sdrf_pkg::CountW-1:0] count_q, count_d;
  logic                        agree;
  logic                        expire;

  // A raw high means released, so the levels agree when they differ as bits.
  assign agree  = raw_released_i != pressed_q;
  assign expire = count_q <= sdrf_pkg::CountW'(1);

  always_comb begin
    pressed_d       = pressed_q;
    count_d         = count_q;
    next_o.released = 1'b0;
    if (ctrl_i.tick) begin
      if (agree) begin
        count_d = pressed_q ? cfg_i.release_count : cfg_i.press_count;
      end else if (expire) begin
        // Toggle and reload for the new state rather than wrapping.
        pressed_d       = ~pressed_q;
        count_d         = pressed_q ? cfg_i.press_count : cfg_i.release_count;
        next_o.released = pressed_q;
      end else begin
        count_d = count_q - sdrf_pkg::CountW'(1);
      end
    end else if (ctrl_i.clear_state) begin
      pressed_d = 1'b0;
    end
    next_o.pressed = pressed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b0;
      count_q   <= sdrf_pkg::PressCountRst;
    end else begin
      pressed_q <= pressed_d;
      count_q   <= count_d;
    end
  end

endmodule

/* sv/switch_debounce_release_flags.sv */
// A result is offered in the cycle after its item is accepted. Throughput: one item per
// cycle when not stalled; the per-switch lanes and the flag merge are a single compare,
// decrement and reload stage, and the output register decouples the two sides.
// Reset: switches read as released, release flags are clear, countdowns hold the press
// count reset value (2), and the registers return to press 2 and release 20 ticks.
module switch_debounce_release_flags (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic [sdrf_pkg::NumSwitches-1:0]    raw_levels_i,
  input  logic [sdrf_pkg::NumSwitches-1:0]    clear_mask_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sdrf_pkg::NumSwitches-1:0]    debounced_pressed_o,
  output logic [sdrf_pkg::NumSwitches-1:0]    release_flags_o,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sdrf_pkg::PaddrW-1:0]         paddr,
  input  logic [sdrf_pkg::ApbDataW-1:0]       pwdata,
  output logic [sdrf_pkg::ApbDataW-1:0]       prdata,
  output logic                                pready
);

  localparam int N = sdrf_pkg::NumSwitches;

  sdrf_pkg::cfg_t       cfg;
  sdrf_pkg::lane_ctrl_t lane_ctrl;
  sdrf_pkg::lane_out_t  lane_next [N];
  sdrf_pkg::op_e        op;

  logic         accept;
  logic [N-1:0] pressed_next;
  logic [N-1:0] released_evt;
  logic [N-1:0] seen_q, seen_d;
  logic         out_valid_q, out_valid_d;
  logic [N-1:0] out_pressed_q;
  logic [N-1:0] out_flags_q;

  // The count registers live in their own small block.
  sdrf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The input side stalls only when the held result has not been taken yet, so
  // a new item enters in the same cycle that the previous result transfers.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign op         = sdrf_pkg::op_e'(operation_i);

  // Every lane sees the same decoded operation; only ticks move the countdowns.
  assign lane_ctrl.tick        = accept && (op == sdrf_pkg::OpTick);
  assign lane_ctrl.clear_state = accept && (op == sdrf_pkg::OpReset);

  for (genvar g = 0; g < N; g++) begin : g_lane
    sdrf_lane u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (lane_ctrl),
      .raw_released_i (raw_levels_i[g]),
      .cfg_i          (cfg),
      .next_o         (lane_next[g])
    );
    assign pressed_next[g] = lane_next[g].pressed;
    assign released_evt[g] = lane_next[g].released;
  end

  // Merge stage: the sticky release flags collect the lanes' release events,
  // drop bits by mask on a clear item, and drop everything on a reset item.
  always_comb begin
    seen_d = seen_q;
    if (accept) begin
      unique case (op)
        sdrf_pkg::OpTick:  seen_d = seen_q | released_evt;
        sdrf_pkg::OpClear: seen_d = seen_q & ~clear_mask_i;
        sdrf_pkg::OpReset: seen_d = '0;
        default:           seen_d = seen_q;
      endcase
    end
  end

  // The result register holds a value until it transfers; an accepted item
  // always produces exactly one result, showing the state after its update.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_pressed_q <= pressed_next;
      out_flags_q   <= seen_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign debounced_pressed_o = out_pressed_q;
  assign release_flags_o     = out_flags_q;

  // A stall toward the source only ever comes from a held result.
  a_stall_needs_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  // A reset item leaves everything released and every flag clear.
  a_reset_item_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == sdrf_pkg::OpReset) |=>
      (debounced_pressed_o == '0 && release_flags_o == '0))
    else $error("reset item left state or flags set");

  // A clear item drops every masked flag in its result.
  a_clear_item_masks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == sdrf_pkg::OpClear) |=>
      ((release_flags_o & $past(clear_mask_i)) == '0))
    else $error("clear item left a masked flag set");

  // Ticks only ever add release flags.
  a_tick_keeps_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == sdrf_pkg::OpTick) |=> ((seen_q & $past(seen_q)) == $past(seen_q)))
    else $error("tick dropped a release flag");

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // An operation code that the block does not define; it must leave the state alone.
  localparam logic [1:0] OpUnused = 2'd3;

  // The block offers a result in the cycle after the item is taken, so this margin after
  // the last result is plenty before a register write or the end of the run.
  localparam int DrainCycles = 4;

  // Cycles without any transfer before the run is declared hung. Stalls and gaps are
  // rare and short, so a normal run never comes near this.
  localparam int HangLimit = 2000;

  // Odds, in percent, that a side idles or stalls in a given cycle.
  localparam int IdlePercent = 7;

  typedef struct packed {
    logic [sdrf_pkg::NumSwitches-1:0] pressed;
    logic [sdrf_pkg::NumSwitches-1:0] flags;
  } switch_view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             in_valid_i   = 1'b0;
  logic                             in_stall_o;
  logic [1:0]                       operation_i  = sdrf_pkg::OpTick;
  logic [sdrf_pkg::NumSwitches-1:0] raw_levels_i = '1;
  logic [sdrf_pkg::NumSwitches-1:0] clear_mask_i = '0;

  logic                             out_valid_o;
  logic                             out_stall_i  = 1'b0;
  logic [sdrf_pkg::NumSwitches-1:0] debounced_pressed_o;
  logic [sdrf_pkg::NumSwitches-1:0] release_flags_o;

  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [sdrf_pkg::PaddrW-1:0]   paddr   = '0;
  logic [sdrf_pkg::ApbDataW-1:0] pwdata  = '0;
  logic [sdrf_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  switch_debounce_release_flags u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .raw_levels_i       (raw_levels_i),
    .clear_mask_i       (clear_mask_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .debounced_pressed_o(debounced_pressed_o),
    .release_flags_o    (release_flags_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Our own copy of the debouncer: count registers, per-switch countdowns, the debounced
  // state and the sticky release flags. It advances once per accepted input transfer.
  logic [sdrf_pkg::CountW-1:0]      press_cfg   = sdrf_pkg::PressCountRst;
  logic [sdrf_pkg::CountW-1:0]      release_cfg = sdrf_pkg::ReleaseCountRst;
  logic [sdrf_pkg::CountW-1:0]      lane_count [sdrf_pkg::NumSwitches];
  logic [sdrf_pkg::NumSwitches-1:0] pressed_now = '0;
  logic [sdrf_pkg::NumSwitches-1:0] flags_now   = '0;

  // Debounced states still owed by the block, oldest first.
  switch_view_t expected_views[$];
  switch_view_t next_view;

  // While quiet is set neither side idles, which gives one long back-to-back stretch.
  bit quiet = 1'b0;

  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int presses_seen    = 0;
  int releases_seen   = 0;
  int settings_used   = 0;

  // Raw pin generator for the random traffic: each pin holds a level for a run of ticks.
  // Long runs let presses and releases get through; short runs act as contact bounce.
  logic pin_level [sdrf_pkg::NumSwitches];
  int   pin_hold_left [sdrf_pkg::NumSwitches];

  initial begin
    for (int i = 0; i < sdrf_pkg::NumSwitches; i++) begin
      lane_count[i]    = sdrf_pkg::PressCountRst;
      pin_level[i]     = 1'b1;
      pin_hold_left[i] = 0;
    end
  end

  // Update the state for one accepted item and queue the view the block must report.
  function automatic void predict_debounce(input logic [1:0] op,
                                           input logic [sdrf_pkg::NumSwitches-1:0] raw,
                                           input logic [sdrf_pkg::NumSwitches-1:0] mask);
    case (op)
      sdrf_pkg::OpTick: begin
        for (int i = 0; i < sdrf_pkg::NumSwitches; i++) begin
          // A raw 1 means released, a debounced 1 means pressed, so differing bits agree.
          if (raw[i] != pressed_now[i]) begin
            lane_count[i] = pressed_now[i] ? release_cfg : press_cfg;
          end else if (lane_count[i] <= 1) begin
            // The countdown expired: toggle and reload for the new state, never wrap.
            if (pressed_now[i]) begin
              flags_now[i]  = 1'b1;
              lane_count[i] = press_cfg;
              releases_seen++;
            end else begin
              lane_count[i] = release_cfg;
              presses_seen++;
            end
            pressed_now[i] = ~pressed_now[i];
          end else begin
            lane_count[i] = lane_count[i] - 1'b1;
          end
        end
      end
      sdrf_pkg::OpClear: begin
        flags_now = flags_now & ~mask;
      end
      sdrf_pkg::OpReset: begin
        // The countdowns are deliberately left as they are.
        pressed_now = '0;
        flags_now   = '0;
      end
      default: begin
      end
    endcase
    expected_views.push_back('{pressed: pressed_now, flags: flags_now});
  endfunction

  // Present one item, hold it through any stall, and predict it at the accepting edge.
  // Called and returns at a falling edge.
  task automatic send_item(input logic [1:0] op,
                           input logic [sdrf_pkg::NumSwitches-1:0] raw,
                           input logic [sdrf_pkg::NumSwitches-1:0] mask);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    raw_levels_i <= raw;
    clear_mask_i <= mask;
    do @(posedge clk_i); while (in_stall_o);
    predict_debounce(op, raw, mask);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every owed result has come back, plus a margin.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (expected_views.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // One register write: setup cycle, then access cycle until pready. The upper data
  // bits carry noise, since only the low byte belongs to the register.
  task automatic write_count_reg(input sdrf_pkg::reg_idx_e idx,
                                 input logic [sdrf_pkg::CountW-1:0] value);
    logic [sdrf_pkg::ApbDataW-1:0] noise;
    noise = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sdrf_pkg::PaddrW'(4 * int'(idx));
    pwdata  <= {noise[sdrf_pkg::ApbDataW-1:sdrf_pkg::CountW], value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == sdrf_pkg::RegPressCount) begin
      press_cfg = value;
    end else begin
      release_cfg = value;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_counts(input logic [sdrf_pkg::CountW-1:0] press_ticks,
                            input logic [sdrf_pkg::CountW-1:0] release_ticks);
    wait_until_drained();
    write_count_reg(sdrf_pkg::RegPressCount, press_ticks);
    write_count_reg(sdrf_pkg::RegReleaseCount, release_ticks);
    settings_used++;
  endtask

  function automatic logic [sdrf_pkg::NumSwitches-1:0] next_pin_levels(input int max_run);
    logic [sdrf_pkg::NumSwitches-1:0] levels;
    for (int i = 0; i < sdrf_pkg::NumSwitches; i++) begin
      if (pin_hold_left[i] == 0) begin
        pin_level[i] = 1'($urandom_range(1));
        if ($urandom_range(99) < 25) begin
          pin_hold_left[i] = $urandom_range(2, 1);
        end else begin
          pin_hold_left[i] = $urandom_range(max_run, 1);
        end
      end
      pin_hold_left[i]--;
      levels[i] = pin_level[i];
    end
    return levels;
  endfunction

  // Power-on registers (press 2, release 20): two pressed ticks must register a press.
  task automatic test_power_on_counts();
    send_item(sdrf_pkg::OpTick, 2'b11, 2'b00);
    send_item(sdrf_pkg::OpTick, 2'b00, 2'b00);
    send_item(sdrf_pkg::OpTick, 2'b00, 2'b00);
  endtask

  // Short counts, a bounce that must reload the countdown, releases that raise flags,
  // clears by mask, a reset item, the unused operation, and payload bits that the
  // operation in question has to ignore.
  task automatic test_release_flags();
    set_counts(8'd1, 8'd3);
    send_item(sdrf_pkg::OpTick, 2'b00, 2'b11);
    send_item(sdrf_pkg::OpTick, 2'b01, 2'b00);
    send_item(sdrf_pkg::OpTick, 2'b00, 2'b00);
    send_item(sdrf_pkg::OpTick, 2'b11, 2'b00);
    send_item(sdrf_pkg::OpTick, 2'b11, 2'b00);
    send_item(sdrf_pkg::OpTick, 2'b11, 2'b00);
    send_item(sdrf_pkg::OpClear, 2'b00, 2'b01);
    send_item(sdrf_pkg::OpTick, 2'b10, 2'b11);
    send_item(sdrf_pkg::OpClear, 2'b11, 2'b11);
    send_item(sdrf_pkg::OpReset, 2'b00, 2'b11);
    send_item(OpUnused, 2'b00, 2'b11);
    send_item(sdrf_pkg::OpTick, 2'b00, 2'b00);
  endtask

  // A zero count register must behave like one; then the largest count.
  task automatic test_count_extremes();
    set_counts(8'd0, 8'd0);
    send_item(sdrf_pkg::OpTick, 2'b01, 2'b00);
    send_item(sdrf_pkg::OpTick, 2'b11, 2'b00);
    send_item(sdrf_pkg::OpTick, 2'b00, 2'b00);
    send_item(sdrf_pkg::OpClear, 2'b00, 2'b10);
    set_counts(8'd255, 8'd255);
    send_item(sdrf_pkg::OpTick, 2'b11, 2'b00);
    send_item(sdrf_pkg::OpTick, 2'b00, 2'b00);
  endtask

  // Mostly ticks from the pin generator, with clears, reset items and the unused code
  // mixed in. Unused payload fields get random values throughout.
  task automatic run_random_phase(input logic [sdrf_pkg::CountW-1:0] press_ticks,
                                  input logic [sdrf_pkg::CountW-1:0] release_ticks,
                                  input int n_items);
    int longest;
    int pick;
    longest = (press_ticks > release_ticks) ? int'(press_ticks) : int'(release_ticks);
    set_counts(press_ticks, release_ticks);
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 86) begin
        send_item(sdrf_pkg::OpTick, next_pin_levels(2 * longest + 2),
                  sdrf_pkg::NumSwitches'($urandom()));
      end else if (pick < 93) begin
        send_item(sdrf_pkg::OpClear, sdrf_pkg::NumSwitches'($urandom()),
                  sdrf_pkg::NumSwitches'($urandom()));
      end else if (pick < 96) begin
        send_item(sdrf_pkg::OpReset, sdrf_pkg::NumSwitches'($urandom()),
                  sdrf_pkg::NumSwitches'($urandom()));
      end else begin
        send_item(OpUnused, sdrf_pkg::NumSwitches'($urandom()),
                  sdrf_pkg::NumSwitches'($urandom()));
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(8'd1, 8'd1, 150);
    run_random_phase(8'd0, 8'd0, 100);
    run_random_phase(sdrf_pkg::PressCountRst, sdrf_pkg::ReleaseCountRst, 250);
    quiet = 1'b1;
    run_random_phase(8'd3, 8'd7, 250);
    quiet = 1'b0;
    run_random_phase(8'd255, 8'd4, 300);
    run_random_phase(sdrf_pkg::CountW'($urandom_range(8, 1)),
                     sdrf_pkg::CountW'($urandom_range(8, 1)), 100);
  endtask

  // The receiver stalls at random, except during the quiet stretch.
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < IdlePercent);
  end

  // Every result transfer is compared with the oldest owed view, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_views.size() == 0) begin
        $error("result transfer with nothing owed: pressed %b flags %b",
               debounced_pressed_o, release_flags_o);
        error_count++;
      end else begin
        next_view = expected_views.pop_front();
        results_checked++;
        if (debounced_pressed_o !== next_view.pressed) begin
          $error("debounced_pressed: expected %b, got %b",
                 next_view.pressed, debounced_pressed_o);
          error_count++;
        end
        if (release_flags_o !== next_view.flags) begin
          $error("release_flags: expected %b, got %b", next_view.flags, release_flags_o);
          error_count++;
        end
      end
    end
  end

  // Hang detector: any transfer on either channel or the register port restarts it.
  initial begin : hang_watch
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HangLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("no transfer for %0d cycles, %0d results still owed",
             HangLimit, expected_views.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_power_on_counts();
    test_release_flags();
    test_count_extremes();
    test_random_traffic();

    wait_until_drained();
    $display("Sent %0d items under %0d count settings and checked %0d results.",
             items_sent, settings_used + 1, results_checked);
    $display("The predicted state saw %0d debounced presses and %0d releases.",
             presses_seen, releases_seen);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sdrf_pkg.sv
sv/sdrf_cfg.sv
sv/sdrf_lane.sv
sv/switch_debounce_release_flags.sv
verif/tb_top.sv
